>>> rtl/srtf_pkg.sv
// Package for the shortest-remaining-time scheduler.
// Holds table sizes, field widths and event codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srtf_pkg;

    localparam int MAX_JOBS    = 16;
    localparam int IDX_BITS    = $clog2(MAX_JOBS);
    localparam int CNT_BITS    = $clog2(MAX_JOBS + 1);
    localparam int LENGTH_BITS = 16;
    localparam int TIME_BITS   = 32;
    localparam int IN_LEN_BITS = 16;
    localparam int ENTRY_BITS  = TIME_BITS + LENGTH_BITS;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] EV_IDLE     = 2'd0;
    localparam logic [1:0] EV_START    = 2'd1;
    localparam logic [1:0] EV_SWITCH   = 2'd2;
    localparam logic [1:0] EV_CONTINUE = 2'd3;

    typedef struct packed {
        logic [TIME_BITS-1:0]   arrival;
        logic [LENGTH_BITS-1:0] remaining;
    } entry_t;

endpackage

`default_nettype wire

>>> rtl/srtf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the job table of the scheduler.
`timescale 1ns / 1ps
`default_nettype none

module srtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/shortest_remaining_time_scheduler_core.sv
// Top level of the shortest-remaining-time-first scheduler.
// Depends on srtf_pkg and srtf_ram (job table of arrival and remaining time).
//
// Usage: one request channel (in_valid / in_stall) carries operation,
// arrival_time and job_length; one result channel (out_valid / out_stall)
// carries event_kind, job_index, event_time, job_finished and all_done.
// A load request appends a job and gives no result; loads past the table
// size are dropped. A tick request scans the job table one entry a cycle
// through the single read port of the job memory, then passes the drain and
// done states (straight to done with an empty table) before its result is
// written to the output register, and the block returns to idle with it.
// The output register holds a result until taken; while it is stalled the
// block keeps taking loads and scans the next tick, then holds that tick
// until the output register frees.
// Reset clears the job count, completed count, time, run history and the
// started flags; the job memory needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module shortest_remaining_time_scheduler_core
    import srtf_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic                   operation,
    input  wire logic [TIME_BITS-1:0]   arrival_time,
    input  wire logic [IN_LEN_BITS-1:0] job_length,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [1:0]                  event_kind,
    output logic [IDX_BITS-1:0]         job_index,
    output logic [TIME_BITS-1:0]        event_time,
    output logic                        job_finished,
    output logic                        all_done
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_BITS-1:0]    job_count_reg, job_count_next;
    logic [CNT_BITS-1:0]    completed_reg, completed_next;
    logic [TIME_BITS-1:0]   time_reg, time_next;
    logic [IDX_BITS-1:0]    last_job_reg, last_job_next;
    logic                   last_valid_reg, last_valid_next;
    logic [MAX_JOBS-1:0]    started_reg, started_next;
    logic [IDX_BITS-1:0]    scan_idx_reg, scan_idx_next;
    logic                   data_valid_reg, data_valid_next;
    logic [IDX_BITS-1:0]    data_idx_reg, data_idx_next;
    logic                   found_reg, found_next;
    logic [IDX_BITS-1:0]    best_idx_reg, best_idx_next;
    logic [LENGTH_BITS-1:0] best_rem_reg, best_rem_next;
    logic [TIME_BITS-1:0]   best_arr_reg, best_arr_next;
    logic                   out_valid_reg, out_valid_next;

    logic [1:0]             kind_reg, kind_next;
    logic [IDX_BITS-1:0]    index_reg, index_next;
    logic [TIME_BITS-1:0]   etime_reg, etime_next;
    logic                   fin_reg, fin_next;
    logic                   done_reg, done_next;

    logic                   wr_en;
    logic [IDX_BITS-1:0]    wr_addr;
    entry_t                 wr_data;
    entry_t                 rd_data;

    logic                   in_accept;
    logic                   out_free;
    logic                   candidate;
    logic [IDX_BITS-1:0]    last_idx;
    logic [LENGTH_BITS-1:0] load_len;
    logic [LENGTH_BITS-1:0] dec_rem;
    logic                   fin;

    srtf_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_JOBS)
    ) u_job_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_data)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign last_idx  = IDX_BITS'(job_count_reg - CNT_BITS'(1));
    assign load_len  = job_length[LENGTH_BITS-1:0];
    assign dec_rem   = best_rem_reg - LENGTH_BITS'(1);
    assign fin       = found_reg && (best_rem_reg == LENGTH_BITS'(1));

    assign candidate = data_valid_reg
                    && (rd_data.remaining != '0)
                    && (rd_data.arrival <= time_reg)
                    && (!found_reg || (rd_data.remaining < best_rem_reg));

    always_comb
    begin
        state_next      = state_reg;
        job_count_next  = job_count_reg;
        completed_next  = completed_reg;
        time_next       = time_reg;
        last_job_next   = last_job_reg;
        last_valid_next = last_valid_reg;
        started_next    = started_reg;
        scan_idx_next   = scan_idx_reg;
        data_valid_next = 1'b0;
        data_idx_next   = scan_idx_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_rem_next   = best_rem_reg;
        best_arr_next   = best_arr_reg;
        out_valid_next  = out_valid_reg && out_stall;
        kind_next       = kind_reg;
        index_next      = index_reg;
        etime_next      = etime_reg;
        fin_next        = fin_reg;
        done_next       = done_reg;
        wr_en           = 1'b0;
        wr_addr         = job_count_reg[IDX_BITS-1:0];
        wr_data.arrival   = arrival_time;
        wr_data.remaining = load_len;

        if (candidate)
        begin
            found_next    = 1'b1;
            best_idx_next = data_idx_reg;
            best_rem_next = rd_data.remaining;
            best_arr_next = rd_data.arrival;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (operation == OP_LOAD)
                    begin
                        if (job_count_reg < CNT_BITS'(MAX_JOBS))
                        begin
                            wr_en          = 1'b1;
                            started_next[job_count_reg[IDX_BITS-1:0]] = 1'b0;
                            job_count_next = job_count_reg + CNT_BITS'(1);
                            if (load_len == '0)
                            begin
                                completed_next = completed_reg + CNT_BITS'(1);
                            end
                        end
                    end
                    else
                    begin
                        found_next    = 1'b0;
                        scan_idx_next = '0;
                        state_next    = (job_count_reg == '0) ? ST_DONE : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                data_valid_next = 1'b1;
                if (scan_idx_reg == last_idx)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IDX_BITS'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    kind_next  = EV_IDLE;
                    index_next = '0;
                    if (found_reg)
                    begin
                        wr_en             = 1'b1;
                        wr_addr           = best_idx_reg;
                        wr_data.arrival   = best_arr_reg;
                        wr_data.remaining = dec_rem;
                        index_next        = best_idx_reg;
                        if (!started_reg[best_idx_reg])
                        begin
                            kind_next = EV_START;
                        end
                        else if (!last_valid_reg || (last_job_reg != best_idx_reg))
                        begin
                            kind_next = EV_SWITCH;
                        end
                        else
                        begin
                            kind_next = EV_CONTINUE;
                        end
                        started_next[best_idx_reg] = 1'b1;
                        last_job_next   = best_idx_reg;
                        last_valid_next = 1'b1;
                        if (fin)
                        begin
                            completed_next = completed_reg + CNT_BITS'(1);
                        end
                    end
                    fin_next       = fin;
                    done_next      = (completed_next == job_count_reg);
                    etime_next     = time_reg;
                    time_next      = time_reg + TIME_BITS'(1);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            job_count_reg  <= '0;
            completed_reg  <= '0;
            time_reg       <= '0;
            last_job_reg   <= '0;
            last_valid_reg <= 1'b0;
            started_reg    <= '0;
            data_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            job_count_reg  <= job_count_next;
            completed_reg  <= completed_next;
            time_reg       <= time_next;
            last_job_reg   <= last_job_next;
            last_valid_reg <= last_valid_next;
            started_reg    <= started_next;
            data_valid_reg <= data_valid_next;
            found_reg      <= found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        data_idx_reg <= data_idx_next;
        best_idx_reg <= best_idx_next;
        best_rem_reg <= best_rem_next;
        best_arr_reg <= best_arr_next;
        kind_reg     <= kind_next;
        index_reg    <= index_next;
        etime_reg    <= etime_next;
        fin_reg      <= fin_next;
        done_reg     <= done_next;
    end

    assign out_valid    = out_valid_reg;
    assign event_kind   = kind_reg;
    assign job_index    = index_reg;
    assign event_time   = etime_reg;
    assign job_finished = fin_reg;
    assign all_done     = done_reg;

    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (completed_reg <= job_count_reg) && (job_count_reg <= CNT_BITS'(MAX_JOBS)))
        else $error("completed or job count out of range");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result produced outside the done state");

    a_finish_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && fin_reg) |-> (kind_reg != EV_IDLE))
        else $error("finished flag on an idle tick");

    a_time_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> (time_reg == $past(time_reg) + TIME_BITS'(1)))
        else $error("time did not advance on a tick");

endmodule

`default_nettype wire
